FILE: hdl/psq_pkg.sv
`timescale 1ns / 1ps
// psq_pkg: shared types, register codes and step helpers of the step sequencer
// depends on nothing; every other file imports it

package psq_pkg;

    localparam int StepCount = 16;
    localparam int STEP_W    = $clog2(StepCount);
    localparam int CNT_W     = STEP_W + 1;
    localparam int LEN_W     = 24;
    localparam int POS_W     = 32;
    localparam int DRAW_W    = 8;
    localparam int CMD_W     = 3;
    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;

    localparam logic [CNT_W-1:0] StepNone = CNT_W'(StepCount);

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MASTER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ARM    = 3'd5;

    localparam logic [2:0] REG_GATE_MASK  = 3'd0;
    localparam logic [2:0] REG_MODE_BITS  = 3'd1;
    localparam logic [2:0] REG_PROB_LOW   = 3'd2;
    localparam logic [2:0] REG_PROB_HIGH  = 3'd3;
    localparam logic [2:0] REG_LOOP_FIRST = 3'd4;
    localparam logic [2:0] REG_LOOP_LAST  = 3'd5;
    localparam logic [2:0] REG_INT_LEN    = 3'd6;
    localparam logic [2:0] REG_VOICE_LEN  = 3'd7;

    localparam logic [1:0] MODE_OFF  = 2'd1;
    localparam logic [1:0] MODE_SKIP = 2'd2;

    typedef struct packed {
        logic [15:0]       gate_mask;
        logic [31:0]       mode_bits;
        logic [63:0]       prob_low;
        logic [63:0]       prob_high;
        logic [STEP_W-1:0] loop_first;
        logic [STEP_W-1:0] loop_last;
        logic [LEN_W-1:0]  int_len;
        logic [LEN_W-1:0]  voice_len;
    } cfg_t;

    function automatic logic [1:0] step_mode(cfg_t cfg, logic [STEP_W-1:0] s);
        step_mode = cfg.mode_bits[{s, 1'b0} +: 2];
    endfunction

    function automatic logic step_passes(cfg_t cfg, logic [STEP_W-1:0] s,
                                         logic [DRAW_W-1:0] draw);
        logic [63:0]       word;
        logic [DRAW_W-1:0] p;
        word = s[STEP_W-1] ? cfg.prob_high : cfg.prob_low;
        p = word[{s[STEP_W-2:0], 3'b000} +: DRAW_W];
        step_passes = cfg.gate_mask[s] && (draw <= p);
    endfunction

    function automatic logic [STEP_W-1:0] eff_last(cfg_t cfg);
        eff_last = (cfg.loop_last < cfg.loop_first) ? cfg.loop_first : cfg.loop_last;
    endfunction

endpackage

FILE: hdl/psq_if.sv
`timescale 1ns / 1ps
// psq_in_if / psq_out_if: valid-ready channels for input and result items
// depends on psq_pkg

interface psq_in_if import psq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  master_position;
    logic [DRAW_W-1:0] random_draw;

    modport source(output valid, command, master_position, random_draw, input ready);
    modport sink(input valid, command, master_position, random_draw, output ready);
endinterface

interface psq_out_if import psq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              trigger;
    logic [STEP_W-1:0] step_now;

    modport source(output valid, trigger, step_now, input ready);
    modport sink(input valid, trigger, step_now, output ready);
endinterface

FILE: hdl/psq_regs.sv
`timescale 1ns / 1ps
// psq_regs: apb configuration register bank of the step sequencer
// depends on psq_pkg

module psq_regs import psq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = paddr[APB_AW-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate_mask  <= '0;
            cfg_reg.mode_bits  <= '0;
            cfg_reg.prob_low   <= '1;
            cfg_reg.prob_high  <= '1;
            cfg_reg.loop_first <= '0;
            cfg_reg.loop_last  <= STEP_W'(StepCount - 1);
            cfg_reg.int_len    <= LEN_W'(5512);
            cfg_reg.voice_len  <= LEN_W'(5512);
        end
        else if (wr_en)
        begin
            case (index)
                REG_GATE_MASK:  cfg_reg.gate_mask  <= pwdata[15:0];
                REG_MODE_BITS:  cfg_reg.mode_bits  <= pwdata[31:0];
                REG_PROB_LOW:   cfg_reg.prob_low   <= pwdata;
                REG_PROB_HIGH:  cfg_reg.prob_high  <= pwdata;
                REG_LOOP_FIRST: cfg_reg.loop_first <= pwdata[STEP_W-1:0];
                REG_LOOP_LAST:  cfg_reg.loop_last  <= pwdata[STEP_W-1:0];
                REG_INT_LEN:    cfg_reg.int_len    <= pwdata[LEN_W-1:0];
                REG_VOICE_LEN:  cfg_reg.voice_len  <= pwdata[LEN_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_GATE_MASK:  prdata = APB_DW'(cfg_reg.gate_mask);
            REG_MODE_BITS:  prdata = APB_DW'(cfg_reg.mode_bits);
            REG_PROB_LOW:   prdata = cfg_reg.prob_low;
            REG_PROB_HIGH:  prdata = cfg_reg.prob_high;
            REG_LOOP_FIRST: prdata = APB_DW'(cfg_reg.loop_first);
            REG_LOOP_LAST:  prdata = APB_DW'(cfg_reg.loop_last);
            REG_INT_LEN:    prdata = APB_DW'(cfg_reg.int_len);
            REG_VOICE_LEN:  prdata = APB_DW'(cfg_reg.voice_len);
            default:        prdata = '0;
        endcase
    end

endmodule

FILE: hdl/psq_div.sv
`timescale 1ns / 1ps
// psq_div: shared restoring divider, one quotient bit per cycle
// depends on psq_pkg

module psq_div import psq_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [LEN_W-1:0] divisor,
    output logic             done,
    output logic [POS_W-1:0] quotient,
    output logic [LEN_W-1:0] remainder
);

    localparam int ITER_W = $clog2(POS_W + 1);

    logic [POS_W-1:0]  quo_reg, quo_next;
    logic [LEN_W:0]    rem_reg, rem_next;
    logic [LEN_W-1:0]  dsr_reg, dsr_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [LEN_W:0]    shifted;
    logic              fits;

    assign shifted   = {rem_reg[LEN_W-1:0], quo_reg[POS_W-1]};
    assign fits      = shifted >= {1'b0, dsr_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[LEN_W-1:0];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = ITER_W'(POS_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, dsr_reg}) : shifted;
            quo_next = {quo_reg[POS_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

FILE: hdl/probabilistic_step_sequencer_unit.sv
`timescale 1ns / 1ps
// probabilistic_step_sequencer_unit: top level, command sequencer and result register
// depends on psq_pkg, psq_if, psq_regs, psq_div

// Looping 16-step sequencer driven one item at a time. Play, stop, reset, arm
// skip and sample ticks pass through the done state: the item is taken, then its
// result is loaded into the output register once that register is free. A master
// tick with any non-skip step in the loop runs the shared divider twice (position
// by voice step length, then quotient by the number of non-skip steps in the
// loop), walks the loop range one step per cycle to find the selected step and
// then applies it. One item is worked on at a time; a finished result may wait
// in the output register while the next item is taken.
module probabilistic_step_sequencer_unit import psq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    psq_in_if.sink            in_ch,
    psq_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_QUOT = 3'd1;
    localparam logic [2:0] ST_MOD  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_FIRE = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    cfg_t cfg;

    logic [2:0]        state_reg, state_next;
    logic [LEN_W-1:0]  counter_reg, counter_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              running_reg, running_next;
    logic              fired_reg, fired_next;
    logic [CNT_W-1:0]  prev_master_reg, prev_master_next;
    logic [POS_W-1:0]  prev_cycle_reg, prev_cycle_next;
    logic              pcv_reg, pcv_next;
    logic              skip_reg, skip_next;
    logic [DRAW_W-1:0] draw_reg, draw_next;
    logic [POS_W-1:0]  q_reg, q_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STEP_W-1:0] rank_reg, rank_next;
    logic [STEP_W-1:0] walk_reg, walk_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_trig_reg, out_trig_next;
    logic [STEP_W-1:0] out_step_reg, out_step_next;

    logic [StepCount-1:0] keep_mask;
    logic [CNT_W-1:0]     keep_count;
    logic [STEP_W-1:0]    last_step;
    logic                 accept;
    logic [LEN_W:0]       count_inc;
    logic [CNT_W-1:0]     step_inc;
    logic                 div_start;
    logic [POS_W-1:0]     div_dividend;
    logic [LEN_W-1:0]     div_divisor;
    logic                 div_done;
    logic [POS_W-1:0]     div_quotient;
    logic [LEN_W-1:0]     div_remainder;
    logic                 fire_ok;

    psq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign last_step = eff_last(cfg);

    always_comb
    begin
        keep_count = '0;
        for (int i = 0; i < StepCount; i++)
        begin
            keep_mask[i] = (STEP_W'(i) >= cfg.loop_first) && (STEP_W'(i) <= last_step)
                           && (step_mode(cfg, STEP_W'(i)) != MODE_SKIP);
            keep_count = keep_count + CNT_W'(keep_mask[i]);
        end
    end

    assign accept    = in_ch.valid && in_ch.ready;
    assign count_inc = {1'b0, counter_reg} + 1'b1;
    assign step_inc  = {1'b0, step_reg} + 1'b1;
    assign fire_ok   = (step_mode(cfg, walk_reg) != MODE_OFF)
                       && step_passes(cfg, walk_reg, draw_reg);

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.trigger  = out_trig_reg;
    assign out_ch.step_now = out_step_reg;

    always_comb
    begin
        state_next       = state_reg;
        counter_next     = counter_reg;
        step_next        = step_reg;
        running_next     = running_reg;
        fired_next       = fired_reg;
        prev_master_next = prev_master_reg;
        prev_cycle_next  = prev_cycle_reg;
        pcv_next         = pcv_reg;
        skip_next        = skip_reg;
        draw_next        = draw_reg;
        q_next           = q_reg;
        count_next       = count_reg;
        rank_next        = rank_reg;
        walk_next        = walk_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_trig_next    = out_trig_reg;
        out_step_next    = out_step_reg;
        div_start        = 1'b0;
        div_dividend     = in_ch.master_position;
        div_divisor      = (cfg.voice_len == '0) ? LEN_W'(1) : cfg.voice_len;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DONE;
                    draw_next  = in_ch.random_draw;
                    case (in_ch.command)
                        CMD_SAMPLE:
                        begin
                            if (running_reg)
                            begin
                                fired_next = 1'b0;
                                if (count_inc < {1'b0, cfg.int_len})
                                begin
                                    counter_next = count_inc[LEN_W-1:0];
                                end
                                else
                                begin
                                    counter_next = '0;
                                    fired_next   = step_passes(cfg, step_reg,
                                                               in_ch.random_draw);
                                    if (step_inc > {1'b0, last_step}
                                        || step_inc >= CNT_W'(StepCount))
                                    begin
                                        step_next = cfg.loop_first;
                                    end
                                    else
                                    begin
                                        step_next = step_inc[STEP_W-1:0];
                                    end
                                end
                            end
                        end
                        CMD_MASTER:
                        begin
                            fired_next = 1'b0;
                            count_next = keep_count;
                            if (keep_count != '0)
                            begin
                                div_start  = 1'b1;
                                state_next = ST_QUOT;
                            end
                        end
                        CMD_PLAY:
                        begin
                            running_next = 1'b1;
                        end
                        CMD_STOP:
                        begin
                            running_next = 1'b0;
                            fired_next   = 1'b0;
                        end
                        CMD_RESET:
                        begin
                            step_next    = cfg.loop_first;
                            counter_next = '0;
                            fired_next   = 1'b0;
                        end
                        CMD_ARM:
                        begin
                            skip_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_QUOT:
            begin
                div_dividend = div_quotient;
                div_divisor  = LEN_W'(count_reg);
                if (div_done)
                begin
                    q_next     = div_quotient;
                    div_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (div_done)
                begin
                    rank_next  = div_remainder[STEP_W-1:0];
                    walk_next  = cfg.loop_first;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (keep_mask[walk_reg] && rank_reg == '0)
                begin
                    state_next = ST_FIRE;
                end
                else
                begin
                    if (keep_mask[walk_reg])
                    begin
                        rank_next = rank_reg - 1'b1;
                    end
                    walk_next = walk_reg + 1'b1;
                end
            end
            ST_FIRE:
            begin
                state_next = ST_DONE;
                if ({1'b0, walk_reg} != prev_master_reg)
                begin
                    prev_master_next = {1'b0, walk_reg};
                    step_next        = walk_reg;
                    if (fire_ok)
                    begin
                        skip_next  = 1'b0;
                        fired_next = !skip_reg;
                    end
                end
                else if (count_reg == CNT_W'(1))
                begin
                    if (!pcv_reg || q_reg != prev_cycle_reg)
                    begin
                        prev_cycle_next = q_reg;
                        pcv_next        = 1'b1;
                        if (fire_ok)
                        begin
                            skip_next  = 1'b0;
                            fired_next = !skip_reg;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_trig_next  = fired_reg;
                    out_step_next  = step_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            counter_reg     <= '0;
            step_reg        <= '0;
            running_reg     <= 1'b0;
            fired_reg       <= 1'b0;
            prev_master_reg <= StepNone;
            prev_cycle_reg  <= '0;
            pcv_reg         <= 1'b0;
            skip_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            counter_reg     <= counter_next;
            step_reg        <= step_next;
            running_reg     <= running_next;
            fired_reg       <= fired_next;
            prev_master_reg <= prev_master_next;
            prev_cycle_reg  <= prev_cycle_next;
            pcv_reg         <= pcv_next;
            skip_reg        <= skip_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_reg     <= draw_next;
        q_reg        <= q_next;
        count_reg    <= count_next;
        rank_reg     <= rank_next;
        walk_reg     <= walk_next;
        out_trig_reg <= out_trig_next;
        out_step_reg <= out_step_next;
    end

    // the walk finds the selected step before leaving the loop range
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (walk_reg <= last_step))
        else $error("step walk ran past loop end");

    // the applied step is a kept step with rank exhausted
    a_fire_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIRE) |-> (rank_reg == '0 && keep_mask[walk_reg]))
        else $error("master tick applied a wrong step");

    // the previous master step is either none or a real step
    a_prev_master: assert property (@(posedge clk) disable iff (!rst_n)
        (prev_master_reg != StepNone) |-> (prev_master_reg < CNT_W'(StepCount)))
        else $error("previous master step out of range");

endmodule

FILE: tb/psq_checker.sv
`timescale 1ns / 1ps
// psq_checker: watches both item channels and the register port of the step sequencer,
// predicts every result from its own copy of state and settings and compares in order
// depends on psq_pkg and psq_if

module psq_checker import psq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    psq_in_if                 in_mon,
    psq_out_if                out_mon,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                mismatches,
    output int                outstanding,
    output int                checked,
    output int                fires
);

    typedef struct packed {
        logic              trigger;
        logic [STEP_W-1:0] step_now;
    } step_result_t;

    cfg_t              regs;
    logic [LEN_W:0]    sample_cnt;
    logic [STEP_W-1:0] cur_step;
    logic              running;
    logic              fired;
    logic [CNT_W-1:0]  last_master_step;
    logic [POS_W-1:0]  last_quot;
    logic              last_quot_valid;
    logic              skip_armed;
    step_result_t      expected_results[$];
    step_result_t      want;
    step_result_t      predicted;

    function automatic logic [1:0] mode_of(logic [STEP_W-1:0] s);
        return regs.mode_bits[2*s +: 2];
    endfunction

    function automatic logic gate_and_chance(logic [STEP_W-1:0] s, logic [DRAW_W-1:0] draw);
        logic [63:0] prob_word;
        logic [7:0]  chance;
        prob_word = (s >= 8) ? regs.prob_high : regs.prob_low;
        chance = prob_word[8*(s%8) +: 8];
        return regs.gate_mask[s] && (draw <= chance);
    endfunction

    // inverted range collapses to the single step loop_first
    function automatic logic [STEP_W-1:0] loop_end();
        return (regs.loop_last < regs.loop_first) ? regs.loop_first : regs.loop_last;
    endfunction

    // an armed skip swallows one firing that gate and chance allow
    task automatic master_fire(logic [STEP_W-1:0] s, logic [DRAW_W-1:0] draw);
        if (mode_of(s) != MODE_OFF && gate_and_chance(s, draw))
        begin
            if (skip_armed)
                skip_armed = 1'b0;
            else
                fired = 1'b1;
        end
    endtask

    task automatic advance_sequencer(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                     input logic [DRAW_W-1:0] draw,
                                     output step_result_t res);
        logic [STEP_W-1:0] members[StepCount];
        int                n_members;
        logic [POS_W-1:0]  divisor;
        logic [POS_W-1:0]  quot;
        logic [STEP_W-1:0] pick;
        logic [CNT_W-1:0]  next_step;
        case (cmd)
            CMD_SAMPLE:
            begin
                if (running)
                begin
                    fired = 1'b0;
                    sample_cnt = sample_cnt + 1'b1;
                    if (sample_cnt >= {1'b0, regs.int_len})
                    begin
                        sample_cnt = '0;
                        if (gate_and_chance(cur_step, draw))
                            fired = 1'b1;
                        next_step = {1'b0, cur_step} + 1'b1;
                        if (next_step > {1'b0, loop_end()})
                            next_step = {1'b0, regs.loop_first};
                        cur_step = next_step[STEP_W-1:0];
                    end
                end
            end
            CMD_MASTER:
            begin
                fired = 1'b0;
                n_members = 0;
                // skip steps drop out of the loop
                for (int s = int'(regs.loop_first); s <= int'(loop_end()); s++)
                begin
                    if (mode_of(STEP_W'(s)) != MODE_SKIP)
                    begin
                        members[n_members] = STEP_W'(s);
                        n_members++;
                    end
                end
                if (n_members != 0)
                begin
                    divisor = (regs.voice_len == '0) ? POS_W'(1) : POS_W'(regs.voice_len);
                    quot = pos / divisor;
                    pick = members[quot % POS_W'(n_members)];
                    if ({1'b0, pick} != last_master_step)
                    begin
                        last_master_step = {1'b0, pick};
                        cur_step = pick;
                        master_fire(pick, draw);
                    end
                    else if (n_members == 1 && (!last_quot_valid || quot != last_quot))
                    begin
                        last_quot = quot;
                        last_quot_valid = 1'b1;
                        master_fire(pick, draw);
                    end
                end
            end
            CMD_PLAY:
                running = 1'b1;
            CMD_STOP:
            begin
                running = 1'b0;
                fired = 1'b0;
            end
            CMD_RESET:
            begin
                cur_step = regs.loop_first;
                sample_cnt = '0;
                fired = 1'b0;
            end
            CMD_ARM:
                skip_armed = 1'b1;
            default:
                ;
        endcase
        res.trigger = fired;
        res.step_now = cur_step;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = '{gate_mask: '0, mode_bits: '0, prob_low: '1, prob_high: '1,
                     loop_first: '0, loop_last: '1, int_len: 24'd5512, voice_len: 24'd5512};
            sample_cnt = '0;
            cur_step = '0;
            running = 1'b0;
            fired = 1'b0;
            last_master_step = StepNone;
            last_quot = '0;
            last_quot_valid = 1'b0;
            skip_armed = 1'b0;
            expected_results.delete();
            mismatches = 0;
            outstanding = 0;
            checked = 0;
            fires = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_AW-1:3])
                    REG_GATE_MASK:  regs.gate_mask = pwdata[15:0];
                    REG_MODE_BITS:  regs.mode_bits = pwdata[31:0];
                    REG_PROB_LOW:   regs.prob_low = pwdata;
                    REG_PROB_HIGH:  regs.prob_high = pwdata;
                    REG_LOOP_FIRST: regs.loop_first = pwdata[STEP_W-1:0];
                    REG_LOOP_LAST:  regs.loop_last = pwdata[STEP_W-1:0];
                    REG_INT_LEN:    regs.int_len = pwdata[LEN_W-1:0];
                    REG_VOICE_LEN:  regs.voice_len = pwdata[LEN_W-1:0];
                    default:        ;
                endcase
            end
            if (out_mon.valid && out_mon.ready)
            begin
                checked++;
                if (out_mon.trigger === 1'b1)
                    fires++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no item waiting, actual trigger %0b step %0d",
                             $time, out_mon.trigger, out_mon.step_now);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_mon.trigger !== want.trigger)
                    begin
                        $display("%0t: trigger mismatch, expected %0b actual %0b",
                                 $time, want.trigger, out_mon.trigger);
                        mismatches++;
                    end
                    if (out_mon.step_now !== want.step_now)
                    begin
                        $display("%0t: step_now mismatch, expected %0d actual %0d",
                                 $time, want.step_now, out_mon.step_now);
                        mismatches++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                advance_sequencer(in_mon.command, in_mon.master_position, in_mon.random_draw,
                                  predicted);
                expected_results.push_back(predicted);
            end
            outstanding = expected_results.size();
        end
    end

endmodule

FILE: tb/probabilistic_step_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// probabilistic_step_sequencer_unit_tb: clock, reset, register writes and item stimulus
// with random idling on both channels; checking is done by psq_checker
// depends on psq_pkg, psq_if, psq_checker and the sequencer RTL

module probabilistic_step_sequencer_unit_tb import psq_pkg::*; ();

    localparam int HalfPeriod = 5;
    localparam int RandPhases = 9;
    localparam int PhaseItems = 100;
    localparam int LongHold   = 300;
    localparam int TimeoutNs  = 5_000_000;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int   mismatches;
    int   outstanding;
    int   checked;
    int   fires;
    bit   idle_on = 1'b1;
    int   holds_asked = 0;
    int   holds_served = 0;
    int   items_sent = 0;
    int   settings_used = 0;
    cfg_t cur_cfg;
    logic [POS_W-1:0] master_run = '0;

    psq_in_if  in_ch();
    psq_out_if out_ch();

    probabilistic_step_sequencer_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    psq_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .fires       (fires)
    );

    always #HalfPeriod clk = ~clk;

    task automatic apb_write(logic [2:0] idx, logic [APB_DW-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // settings change only once every result is back
    task automatic write_settings(cfg_t c);
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        apb_write(REG_GATE_MASK, 64'(c.gate_mask));
        apb_write(REG_MODE_BITS, 64'(c.mode_bits));
        apb_write(REG_PROB_LOW, c.prob_low);
        apb_write(REG_PROB_HIGH, c.prob_high);
        apb_write(REG_LOOP_FIRST, 64'(c.loop_first));
        apb_write(REG_LOOP_LAST, 64'(c.loop_last));
        apb_write(REG_INT_LEN, 64'(c.int_len));
        apb_write(REG_VOICE_LEN, 64'(c.voice_len));
        cur_cfg = c;
        settings_used++;
    endtask

    task automatic offer_item(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic [DRAW_W-1:0] draw);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.command = cmd;
        in_ch.master_position = pos;
        in_ch.random_draw = draw;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                out_ch.ready = 1'b0;
                repeat (LongHold - 1) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    initial
    begin
        #(TimeoutNs);
        $display("timeout with %0d results outstanding", outstanding);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        cfg_t             c;
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] span;
        logic [3:0]       lo;

        in_ch.valid = 1'b0;
        in_ch.command = CMD_SAMPLE;
        in_ch.master_position = '0;
        in_ch.random_draw = '0;
        cur_cfg = '{gate_mask: '0, mode_bits: '0, prob_low: '1, prob_high: '1,
                    loop_first: '0, loop_last: '1, int_len: 24'd5512, voice_len: 24'd5512};
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: stopped tick, closed gates, unused codes
        offer_item(CMD_SAMPLE, '0, '0);
        offer_item(CMD_MASTER, '0, '0);
        offer_item(CMD_SPARE_A, '1, '1);
        offer_item(CMD_SPARE_B, '1, '1);

        // all gates open, shortest step lengths
        c = cur_cfg;
        c.gate_mask = '1;
        c.int_len = 24'd1;
        c.voice_len = 24'd1;
        write_settings(c);
        offer_item(CMD_PLAY, '0, '0);
        offer_item(CMD_SAMPLE, '0, 8'd255);
        offer_item(CMD_SAMPLE, '0, 8'd128);
        offer_item(CMD_ARM, '0, '0);
        offer_item(CMD_SAMPLE, '0, '0);
        offer_item(CMD_MASTER, 32'd5, '0);
        offer_item(CMD_MASTER, 32'd6, 8'd255);
        offer_item(CMD_RESET, '0, '0);
        offer_item(CMD_MASTER, '1, '0);
        offer_item(CMD_STOP, '0, '0);

        // inverted loop, zero probabilities, zero lengths
        c.gate_mask = 16'h7fff;
        c.prob_low = '0;
        c.prob_high = '0;
        c.loop_first = 4'd9;
        c.loop_last = 4'd3;
        c.int_len = '0;
        c.voice_len = '0;
        write_settings(c);
        offer_item(CMD_PLAY, '0, '0);
        offer_item(CMD_SAMPLE, '0, '0);
        offer_item(CMD_MASTER, 32'd3, 8'd1);
        offer_item(CMD_MASTER, 32'd3, '0);
        offer_item(CMD_MASTER, 32'd3, '0);
        offer_item(CMD_MASTER, 32'd4, '0);

        // off step with an armed skip, longest lengths
        c.mode_bits = 32'(MODE_OFF) << 18;
        c.int_len = '1;
        c.voice_len = '1;
        write_settings(c);
        offer_item(CMD_ARM, '0, '0);
        offer_item(CMD_MASTER, '1, '0);

        // every step in skip mode
        c.mode_bits = {16{MODE_SKIP}};
        c.gate_mask = '1;
        c.prob_low = '1;
        c.prob_high = '1;
        c.loop_first = '0;
        c.loop_last = '1;
        write_settings(c);
        offer_item(CMD_MASTER, '0, '0);
        offer_item(CMD_SAMPLE, '0, 8'd255);
        offer_item(CMD_STOP, '0, '0);

        for (int ph = 0; ph < RandPhases; ph++)
        begin
            idle_on = (ph != RandPhases - 1);
            case ($urandom_range(0, 3))
                0:       c.gate_mask = '1;
                1:       c.gate_mask = '0;
                default: c.gate_mask = 16'($urandom());
            endcase
            case ($urandom_range(0, 5))
                0:       c.mode_bits = '0;
                1:       c.mode_bits = '1;
                2:       c.mode_bits = {16{MODE_SKIP}};
                default: c.mode_bits = $urandom();
            endcase
            case ($urandom_range(0, 3))
                0:
                begin
                    c.prob_low = '1;
                    c.prob_high = '1;
                end
                1:
                begin
                    c.prob_low = '0;
                    c.prob_high = '0;
                end
                default:
                begin
                    c.prob_low = {$urandom(), $urandom()};
                    c.prob_high = {$urandom(), $urandom()};
                end
            endcase
            lo = 4'($urandom());
            case ($urandom_range(0, 3))
                0:
                begin
                    c.loop_first = '0;
                    c.loop_last = '1;
                end
                1:
                begin
                    c.loop_first = lo;
                    c.loop_last = lo;
                end
                2:
                begin
                    c.loop_first = lo;
                    c.loop_last = (lo > 4'd12) ? 4'hf : lo + 4'($urandom_range(1, 3));
                end
                default:
                begin
                    c.loop_first = lo;
                    c.loop_last = 4'($urandom());
                end
            endcase
            case ($urandom_range(0, 9))
                0:       c.int_len = '1;
                1:       c.int_len = 24'($urandom_range(0, 40));
                default: c.int_len = 24'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 9))
                0:       c.voice_len = '1;
                1:       c.voice_len = 24'($urandom());
                default: c.voice_len = 24'($urandom_range(0, 6));
            endcase
            write_settings(c);
            if (ph == 1)
                holds_asked++;
            if ($urandom_range(0, 3) != 0)
                offer_item(CMD_PLAY, $urandom(), 8'($urandom()));

            for (int k = 0; k < PhaseItems; k++)
            begin
                pick = $urandom_range(0, 99);
                span = (cur_cfg.voice_len == '0) ? POS_W'(1) : POS_W'(cur_cfg.voice_len);
                if (pick < 42)
                    cmd = CMD_SAMPLE;
                else if (pick < 78)
                    cmd = CMD_MASTER;
                else if (pick < 86)
                    cmd = CMD_PLAY;
                else if (pick < 90)
                    cmd = CMD_STOP;
                else if (pick < 93)
                    cmd = CMD_RESET;
                else if (pick < 98)
                    cmd = CMD_ARM;
                else
                    cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
                // mostly a master clock moving forward by up to one step
                if ($urandom_range(0, 9) < 7)
                begin
                    master_run = master_run + POS_W'($urandom_range(0, span));
                    pos = master_run;
                end
                else
                    pos = $urandom();
                offer_item(cmd, pos, 8'($urandom()));
            end
        end

        idle_on = 1'b0;
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("run covered %0d items over %0d register settings: %0d results checked, %0d fired",
                 items_sent, settings_used, checked, fires);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
